FILE: design/mprc_pkg.sv
`default_nettype none

package mprc_pkg;

    // poll grid defaults
    localparam int NUM_SLAVES_DEF   = 3;
    localparam int NUM_CHANNELS_DEF = 8;

    // fixed field widths
    localparam int BYTE_W   = 8;
    localparam int SLAVE_W  = 2;
    localparam int CHAN_W   = 3;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 3;

    localparam int IN_DATA_W  = 7 * BYTE_W;
    localparam int OUT_DATA_W = 24;

    localparam logic [BYTE_W-1:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [BYTE_W-1:0] MAX_COUNT         = 8'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK    = 3'd0;
    localparam status_t ST_ADDR  = 3'd1;
    localparam status_t ST_CRC   = 3'd2;
    localparam status_t ST_FUNC  = 3'd3;
    localparam status_t ST_COUNT = 3'd4;

    // one byte of modbus crc-16, reflected, lsb first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                               input logic [7:0] data_in);
        logic [15:0] crc;
        crc = crc_in ^ {8'd0, data_in};
        for (int b = 0; b < 8; b++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

FILE: design/modbus_poll_response_checker.sv
`default_nettype none
// modbus poll response checker
// one input transaction on s_axis is one received 7-byte read-holding-register
// response frame; one output transaction on m_axis is its check result.
// the block walks a poll grid of NUM_SLAVES by NUM_CHANNELS, slave-major,
// and advances one position per frame whatever the outcome. frames are
// checked in order: address (slave index + 1), modbus crc-16 over bytes 0..4,
// function code 0x03, byte count 0..2. a passing frame shifts its data bytes
// into the 16-bit value of the polled channel; any failure stores 0.
// two register stages, input register and result register: a frame accepted
// into the input register moves on to the result register, which drives m_axis.
// throughput: one frame per cycle unless m_axis_tready stalls; the crc is split
// over the two stages (address, function, count bytes before the input register,
// data bytes after it) and the channel table is a register file read and written
// in the result stage, so back-to-back frames on the same channel see each other.
// reset: poll position returns to slave 0 channel 0, all channel values clear
// to 0, both stages empty. no clearing pass is needed.
// stall: when m_axis_tready is low the result holds, the input register holds
// its frame, and s_axis_tready drops once the input register is full too.
module modbus_poll_response_checker #(
    parameter int NUM_SLAVES   = mprc_pkg::NUM_SLAVES_DEF,
    parameter int NUM_CHANNELS = mprc_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // addr_byte, func_byte, count_byte, data_hi, data_lo, crc_first, crc_second
    input  wire logic [mprc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // slave_index, channel_index, channel_value, zero pad
    output logic [mprc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // status
    output logic [mprc_pkg::STATUS_W-1:0]          m_axis_tuser,
    // round_done
    output logic                                   m_axis_tlast
);
    import mprc_pkg::*;

    localparam int DEPTH = NUM_SLAVES * NUM_CHANNELS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // input stage
    logic              in_vld_reg;
    logic [BYTE_W-1:0] addr_reg, func_reg, count_reg, data_hi_reg, data_lo_reg;
    logic [BYTE_W-1:0] crc_first_reg, crc_second_reg;
    logic [15:0]       crc_part_reg;
    logic [15:0]       crc_part_next;

    // poll position and channel table
    logic [SLAVE_W-1:0] slave_reg;
    logic [CHAN_W-1:0]  chan_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [VALUE_W-1:0] store_reg [DEPTH];

    // result stage
    logic               out_vld_reg;
    logic [SLAVE_W-1:0] out_slave_reg;
    logic [CHAN_W-1:0]  out_chan_reg;
    logic [VALUE_W-1:0] out_value_reg;
    status_t            out_status_reg;
    logic               out_last_reg;

    logic               advance;
    logic               in_take;
    logic [15:0]        crc_full;
    logic [VALUE_W-1:0] old_value;
    logic [VALUE_W-1:0] value_next;
    status_t            status_next;
    logic               last_slave, last_chan, last_next;
    logic [BYTE_W-1:0]  expect_addr;

    // result register free or draining this cycle
    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // crc over address, function and count bytes before the input register
    always_comb
    begin
        crc_part_next = crc16_step(CRC_INIT, s_axis_tdata[7:0]);
        crc_part_next = crc16_step(crc_part_next, s_axis_tdata[15:8]);
        crc_part_next = crc16_step(crc_part_next, s_axis_tdata[23:16]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            addr_reg       <= s_axis_tdata[7:0];
            func_reg       <= s_axis_tdata[15:8];
            count_reg      <= s_axis_tdata[23:16];
            data_hi_reg    <= s_axis_tdata[31:24];
            data_lo_reg    <= s_axis_tdata[39:32];
            crc_first_reg  <= s_axis_tdata[47:40];
            crc_second_reg <= s_axis_tdata[55:48];
            crc_part_reg   <= crc_part_next;
        end
    end

    // check logic of the result stage
    always_comb
    begin
        crc_full    = crc16_step(crc16_step(crc_part_reg, data_hi_reg), data_lo_reg);
        old_value   = store_reg[slot_reg];
        expect_addr = {{(BYTE_W-SLAVE_W){1'b0}}, slave_reg} + 8'd1;
        last_slave  = (slave_reg == SLAVE_W'(NUM_SLAVES - 1));
        last_chan   = (chan_reg == CHAN_W'(NUM_CHANNELS - 1));
        last_next   = last_slave && last_chan;

        if (addr_reg != expect_addr)
        begin
            status_next = ST_ADDR;
        end
        else if (crc_first_reg != crc_full[7:0] || crc_second_reg != crc_full[15:8])
        begin
            status_next = ST_CRC;
        end
        else if (func_reg != FUNC_READ_HOLDING)
        begin
            status_next = ST_FUNC;
        end
        else if (count_reg > MAX_COUNT)
        begin
            status_next = ST_COUNT;
        end
        else
        begin
            status_next = ST_OK;
        end

        value_next = '0;
        if (status_next == ST_OK)
        begin
            case (count_reg[1:0])
                2'd0:    value_next = old_value;
                2'd1:    value_next = {old_value[7:0], data_hi_reg};
                2'd2:    value_next = {data_hi_reg, data_lo_reg};
                default: value_next = '0;
            endcase
        end
    end

    // poll position, slave-major with wrap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_reg <= '0;
            chan_reg  <= '0;
            slot_reg  <= '0;
        end
        else if (advance)
        begin
            if (last_chan)
            begin
                chan_reg  <= '0;
                slave_reg <= last_slave ? '0 : slave_reg + 2'd1;
            end
            else
            begin
                chan_reg <= chan_reg + 3'd1;
            end
            slot_reg <= (slot_reg == IDX_W'(DEPTH - 1)) ? '0 : slot_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            store_reg[slot_reg] <= value_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_slave_reg  <= slave_reg;
            out_chan_reg   <= chan_reg;
            out_value_reg  <= value_next;
            out_status_reg <= status_next;
            out_last_reg   <= last_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {3'd0, out_value_reg, out_chan_reg, out_slave_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire
